/* rtl/segtri_pkg.sv */
// Shared constants and register index codes for the segment-triangle test.
package segtri_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int VERTEX_W       = 48;
    localparam int INDEX_W        = 2;

    typedef enum logic [INDEX_W-1:0] {
        IDX_VERTEX0 = 2'd0,
        IDX_VERTEX1 = 2'd1,
        IDX_VERTEX2 = 2'd2
    } reg_index_t;

endpackage

/* rtl/segtri_cross.sv */
// Cross product stage: triangle normal and the cross product of the two endpoint offsets.
module segtri_cross
    import segtri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic signed [COORD_BITS:0] a [3],
    input  logic signed [COORD_BITS:0] b [3],
    input  logic signed [COORD_BITS:0] u [3],
    input  logic signed [COORD_BITS:0] v [3],
    output logic                      valid_out,
    output logic signed [2*COORD_BITS+2:0] n [3],
    output logic signed [2*COORD_BITS+2:0] c [3],
    output logic signed [COORD_BITS:0] a_out [3],
    output logic signed [COORD_BITS:0] b_out [3],
    output logic signed [COORD_BITS:0] u_out [3],
    output logic signed [COORD_BITS:0] v_out [3]
);

    localparam int AW = COORD_BITS + 1;
    localparam int PW = 2 * AW;
    localparam int NW = PW + 1;

    logic signed [PW-1:0] np [6];
    logic signed [PW-1:0] cp [6];
    logic signed [NW-1:0] n_next [3];
    logic signed [NW-1:0] c_next [3];
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] c_reg [3];
    logic signed [AW-1:0] a_reg [3];
    logic signed [AW-1:0] b_reg [3];
    logic signed [AW-1:0] u_reg [3];
    logic signed [AW-1:0] v_reg [3];
    logic                 valid_reg;

    assign np[0] = u[1] * v[2];
    assign np[1] = u[2] * v[1];
    assign np[2] = u[2] * v[0];
    assign np[3] = u[0] * v[2];
    assign np[4] = u[0] * v[1];
    assign np[5] = u[1] * v[0];
    assign cp[0] = a[1] * b[2];
    assign cp[1] = a[2] * b[1];
    assign cp[2] = a[2] * b[0];
    assign cp[3] = a[0] * b[2];
    assign cp[4] = a[0] * b[1];
    assign cp[5] = a[1] * b[0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = NW'(np[2*i]) - NW'(np[2*i+1]);
            c_next[i] = NW'(cp[2*i]) - NW'(cp[2*i+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i] <= n_next[i];
            c_reg[i] <= c_next[i];
            a_reg[i] <= a[i];
            b_reg[i] <= b[i];
            u_reg[i] <= u[i];
            v_reg[i] <= v[i];
        end
    end

    assign valid_out = valid_reg;
    assign n     = n_reg;
    assign c     = c_reg;
    assign a_out = a_reg;
    assign b_out = b_reg;
    assign u_out = u_reg;
    assign v_out = v_reg;

endmodule

/* rtl/segtri_dot.sv */
// Dot product stages: plane distances da, db and edge volumes sn, tn; products then sums.
module segtri_dot
    import segtri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [2*COORD_BITS+2:0] n [3],
    input  logic signed [2*COORD_BITS+2:0] c [3],
    input  logic signed [COORD_BITS:0]     a [3],
    input  logic signed [COORD_BITS:0]     b [3],
    input  logic signed [COORD_BITS:0]     u [3],
    input  logic signed [COORD_BITS:0]     v [3],
    output logic                           valid_out,
    output logic                           normal_ok,
    output logic signed [3*COORD_BITS+5:0] da,
    output logic signed [3*COORD_BITS+5:0] db,
    output logic signed [3*COORD_BITS+5:0] sn,
    output logic signed [3*COORD_BITS+5:0] tn
);

    localparam int AW = COORD_BITS + 1;
    localparam int NW = 2 * COORD_BITS + 3;
    localparam int PW = AW + NW;
    localparam int DW = PW + 2;

    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic signed [PW-1:0] pv_reg [3];
    logic signed [PW-1:0] pu_reg [3];
    logic                 nz_reg;
    logic                 v1_reg;
    logic signed [DW-1:0] da_reg;
    logic signed [DW-1:0] db_reg;
    logic signed [DW-1:0] sn_reg;
    logic signed [DW-1:0] tn_reg;
    logic                 nz2_reg;
    logic                 v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i] <= PW'(a[i]) * PW'(n[i]);
            pb_reg[i] <= PW'(b[i]) * PW'(n[i]);
            pv_reg[i] <= PW'(c[i]) * PW'(v[i]);
            pu_reg[i] <= PW'(c[i]) * PW'(u[i]);
        end
        nz_reg  <= (n[0] != '0) || (n[1] != '0) || (n[2] != '0);
        da_reg  <= DW'(pa_reg[0]) + DW'(pa_reg[1]) + DW'(pa_reg[2]);
        db_reg  <= DW'(pb_reg[0]) + DW'(pb_reg[1]) + DW'(pb_reg[2]);
        sn_reg  <= -(DW'(pv_reg[0]) + DW'(pv_reg[1]) + DW'(pv_reg[2]));
        tn_reg  <= DW'(pu_reg[0]) + DW'(pu_reg[1]) + DW'(pu_reg[2]);
        nz2_reg <= nz_reg;
    end

    assign valid_out = v2_reg;
    assign normal_ok = nz2_reg;
    assign da = da_reg;
    assign db = db_reg;
    assign sn = sn_reg;
    assign tn = tn_reg;

endmodule

/* rtl/segment_triangle_intersection.sv */
// Top level of the pipelined segment versus triangle intersection test.
//
// Usage: write the three vertex registers through wr_en, wr_index and wr_data
// while no request is in flight. A request is taken at every rising edge where
// start is high; busy is always low, so one request can enter every cycle.
// The request carries the segment endpoints start_x..end_z.
// Each request yields exactly one result: done is high for
// one cycle with hit and degenerate valid in that cycle. Results leave in the
// order the requests came in, at the same rate of one per cycle.
// The five stages are: endpoint offsets, cross products, component products,
// dot sums, and the final sign tests. Every stage is one register level.
// degenerate is set when the triangle normal is zero; hit is then low.
// The receiver cannot stall, so the pipeline never holds.
// Reset clears the vertex registers and all stage valid bits; requests in
// flight at reset are dropped.
module segment_triangle_intersection
    import segtri_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        start_z,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,
    input  logic [COORD_BITS-1:0]        end_z,
    input  logic                         wr_en,
    input  logic [INDEX_W-1:0]           wr_index,
    input  logic [VERTEX_W-1:0]          wr_data,
    output logic                         done,
    output logic                         hit,
    output logic                         degenerate
);

    localparam int AW = COORD_BITS + 1;
    localparam int NW = 2 * COORD_BITS + 3;
    localparam int DW = 3 * COORD_BITS + 6;
    localparam int EW = DW + 3;
    localparam int XW = 3 * COORD_BITS + VERTEX_W;

    logic [VERTEX_W-1:0]  vert_reg [3];
    logic signed [AW-1:0] p [3][3];
    logic signed [AW-1:0] ea [3];
    logic signed [AW-1:0] eb [3];
    logic signed [AW-1:0] a_reg [3];
    logic signed [AW-1:0] b_reg [3];
    logic signed [AW-1:0] u_reg [3];
    logic signed [AW-1:0] v_reg [3];
    logic                 s1_valid_reg;

    logic                 s2_valid;
    logic signed [NW-1:0] s2_n [3];
    logic signed [NW-1:0] s2_c [3];
    logic signed [AW-1:0] s2_a [3];
    logic signed [AW-1:0] s2_b [3];
    logic signed [AW-1:0] s2_u [3];
    logic signed [AW-1:0] s2_v [3];

    logic                 s4_valid;
    logic                 s4_nz;
    logic signed [DW-1:0] s4_da;
    logic signed [DW-1:0] s4_db;
    logic signed [DW-1:0] s4_sn;
    logic signed [DW-1:0] s4_tn;

    logic signed [EW-1:0] den;
    logic signed [EW-1:0] rest;
    logic                 s_ok;
    logic                 t_ok;
    logic                 r_ok;
    logic                 same_side;
    logic                 hit_next;
    logic                 done_reg;
    logic                 hit_reg;
    logic                 deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vert_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                IDX_VERTEX0: vert_reg[0] <= wr_data;
                IDX_VERTEX1: vert_reg[1] <= wr_data;
                IDX_VERTEX2: vert_reg[2] <= wr_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        logic [XW-1:0]         ext;
        logic [COORD_BITS-1:0] f;
        for (int k = 0; k < 3; k++)
        begin
            ext = XW'(vert_reg[k]);
            for (int j = 0; j < 3; j++)
            begin
                f = ext[j*COORD_BITS +: COORD_BITS];
                p[k][j] = $signed({f[COORD_BITS-1], f});
            end
        end
    end

    assign ea[0] = $signed({start_x[COORD_BITS-1], start_x});
    assign ea[1] = $signed({start_y[COORD_BITS-1], start_y});
    assign ea[2] = $signed({start_z[COORD_BITS-1], start_z});
    assign eb[0] = $signed({end_x[COORD_BITS-1], end_x});
    assign eb[1] = $signed({end_y[COORD_BITS-1], end_y});
    assign eb[2] = $signed({end_z[COORD_BITS-1], end_z});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_reg[i] <= ea[i] - p[0][i];
            b_reg[i] <= eb[i] - p[0][i];
            u_reg[i] <= p[1][i] - p[0][i];
            v_reg[i] <= p[2][i] - p[0][i];
        end
    end

    segtri_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid_reg),
        .a         (a_reg),
        .b         (b_reg),
        .u         (u_reg),
        .v         (v_reg),
        .valid_out (s2_valid),
        .n         (s2_n),
        .c         (s2_c),
        .a_out     (s2_a),
        .b_out     (s2_b),
        .u_out     (s2_u),
        .v_out     (s2_v)
    );

    segtri_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .n         (s2_n),
        .c         (s2_c),
        .a         (s2_a),
        .b         (s2_b),
        .u         (s2_u),
        .v         (s2_v),
        .valid_out (s4_valid),
        .normal_ok (s4_nz),
        .da        (s4_da),
        .db        (s4_db),
        .sn        (s4_sn),
        .tn        (s4_tn)
    );

    // The crossing tests are scaled by den, whose sign selects the comparisons.
    always_comb
    begin
        same_side = (s4_da != '0) && (s4_db != '0) && (s4_da[DW-1] == s4_db[DW-1]);
        den       = EW'(s4_db) - EW'(s4_da);
        rest      = EW'(s4_db) - EW'(s4_da) - EW'(s4_sn) - EW'(s4_tn);
        if (den[EW-1])
        begin
            s_ok = s4_sn[DW-1] || (s4_sn == '0);
            t_ok = s4_tn[DW-1] || (s4_tn == '0);
            r_ok = rest[EW-1] || (rest == '0);
        end
        else
        begin
            s_ok = !s4_sn[DW-1];
            t_ok = !s4_tn[DW-1];
            r_ok = !rest[EW-1];
        end
        hit_next  = !same_side && s4_nz && (den != '0) && s_ok && t_ok && r_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        deg_reg <= !s4_nz;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign degenerate = deg_reg;

`ifndef NO_ASSERTIONS
    a_hit_not_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && degenerate))
        else $error("hit and degenerate both set");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("request did not produce a result after five cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid |-> $past(s2_valid, 2))
        else $error("dot stage valid without cross stage valid");
`endif

endmodule
